// ===== hdl/irsc_pkg.sv =====
// Shared constants, types and store request struct for the IR sample capture forwarder.
package irsc_pkg;

    // Store geometry
    localparam int STORE_BYTES = 512;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int WIN_W       = ADDR_W + 1;          // holds 0..STORE_BYTES
    localparam int SI_W        = ADDR_W + 4;          // holds 0..STORE_BYTES*8

    // Register field widths and compare width
    localparam int CAP_W  = 10;
    localparam int MINA_W = 9;
    localparam int CMP_W  = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_BYTES    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ACTIVE_BYTES = 8'd1;

    // Reset values and the byte 0 marker
    localparam logic [CAP_W-1:0]  CAPTURE_BYTES_RESET    = 10'd400;
    localparam logic [MINA_W-1:0] MIN_ACTIVE_BYTES_RESET = 9'd20;
    localparam logic [7:0]        SEED_MARKER            = 8'd128;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_BIT_WR,
        ST_FWD_CHK,
        ST_FWD_DATA,
        ST_DONE
    } state_t;

    // One write port and one registered read port per cycle
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } store_req_t;

endpackage

// ===== hdl/ir_sample_capture_forwarder.sv =====
// Top level: sample tick sequencer, configuration registers and result register.
//
// Each input beat is one sample tick of an active-low IR receiver; each tick gives exactly
// one output beat. A tick's steps through the sequencer are serialised on the byte store:
// a read-modify-write of the captured bit and a read of the forwarded byte
// go through it one after the other. After reset, and on an idle tick with the line high
// while byte 0 of the store is nonzero, the store is swept to zero one byte per clock over
// all STORE_BYTES (512) bytes before that tick (or the start after reset) ends; s_axis_tready
// stays low during the sweep while configuration writes are still taken. A finished result
// waits in the output register while the next tick is accepted. Output tdata: bit 0
// send_valid, bits 8:1 send_byte, bit 9 capturing.
module ir_sample_capture_forwarder (
    input  logic                                clk,
    input  logic                                rst_n,
    // input ticks
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [0] line_level, [1] tx_ready
    // results
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [15:0]                         m_axis_tdata,  // [0] send_valid,
                                                               // [8:1] send_byte, [9] capturing
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [irsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [irsc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import irsc_pkg::*;

    // control registers
    state_t             state_reg, state_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic [MINA_W-1:0]  mina_reg, mina_next;
    logic [SI_W-1:0]    si_reg, si_next;
    logic [ADDR_W-1:0]  lab_reg, lab_next;
    logic [WIN_W-1:0]   fi_reg, fi_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    logic               item_reg, item_next;
    logic [7:0]         byte0_reg, byte0_next;
    logic               out_valid_reg, out_valid_next;

    // payload registers
    logic               low_reg, low_next;
    logic               rdy_reg, rdy_next;
    logic               sv_reg, sv_next;
    logic [7:0]         sb_reg, sb_next;
    logic [15:0]        out_data_reg, out_data_next;

    store_req_t         store_req;
    logic [7:0]         store_rd_data;

    // derived conditions
    logic [WIN_W-1:0]   win;
    logic [SI_W-1:0]    win8;
    logic [WIN_W-1:0]   byte_nr;
    logic               active;
    logic               in_window;
    logic               act_ok;
    logic               drain_ok;
    logic               fwd_ok;
    logic               clr_last;
    logic               in_accept;
    logic               out_free;

    irsc_store u_store (
        .clk     (clk),
        .req     (store_req),
        .rd_data (store_rd_data)
    );

    // window saturated to the store size
    always_comb
    begin
        if (CMP_W'(cap_reg) > CMP_W'(STORE_BYTES))
        begin
            win = WIN_W'(STORE_BYTES);
        end
        else
        begin
            win = WIN_W'(cap_reg);
        end
    end

    assign win8      = {win, 3'b000};
    assign byte_nr   = si_reg[SI_W-1:3];
    assign active    = (si_reg != '0);
    assign in_window = (si_reg < win8);
    assign act_ok    = (CMP_W'(lab_reg) > CMP_W'(mina_reg));
    assign drain_ok  = (fi_reg < win) && act_ok;
    assign fwd_ok    = (byte_nr > fi_reg) && act_ok && rdy_reg;
    assign clr_last  = (clr_reg == ADDR_W'(STORE_BYTES - 1));
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = item_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (active)
                begin
                    if (in_window)
                    begin
                        state_next = low_reg ? ST_BIT_WR : ST_FWD_CHK;
                    end
                    else if (drain_ok && rdy_reg)
                    begin
                        state_next = ST_FWD_DATA;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (!low_reg && byte0_reg != 8'd0)
                begin
                    state_next = ST_CLEAR;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_BIT_WR:
            begin
                state_next = ST_FWD_CHK;
            end
            ST_FWD_CHK:
            begin
                state_next = fwd_ok ? ST_FWD_DATA : ST_DONE;
            end
            ST_FWD_DATA:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs: input ready and store requests
    always_comb
    begin
        s_axis_tready     = (state_reg == ST_IDLE);
        store_req         = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                store_req.wr_en   = 1'b1;
                store_req.wr_addr = clr_reg;
                store_req.wr_data = 8'd0;
            end
            ST_EVAL:
            begin
                if (active && in_window && low_reg)
                begin
                    store_req.rd_en   = 1'b1;
                    store_req.rd_addr = byte_nr[ADDR_W-1:0];
                end
                else if (active && !in_window && drain_ok && rdy_reg)
                begin
                    store_req.rd_en   = 1'b1;
                    store_req.rd_addr = fi_reg[ADDR_W-1:0];
                end
                else if (!active && low_reg)
                begin
                    store_req.wr_en   = 1'b1;
                    store_req.wr_addr = '0;
                    store_req.wr_data = SEED_MARKER;
                end
            end
            ST_BIT_WR:
            begin
                store_req.wr_en   = 1'b1;
                store_req.wr_addr = byte_nr[ADDR_W-1:0];
                store_req.wr_data = store_rd_data | (8'b1 << si_reg[2:0]);
            end
            ST_FWD_CHK:
            begin
                if (fwd_ok)
                begin
                    store_req.rd_en   = 1'b1;
                    store_req.rd_addr = fi_reg[ADDR_W-1:0];
                end
            end
            default:
            begin
                store_req = '0;
            end
        endcase
    end

    // datapath and counters
    always_comb
    begin
        cap_next       = cap_reg;
        mina_next      = mina_reg;
        si_next        = si_reg;
        lab_next       = lab_reg;
        fi_next        = fi_reg;
        clr_next       = clr_reg;
        item_next      = item_reg;
        byte0_next     = byte0_reg;
        out_valid_next = out_valid_reg;
        low_next       = low_reg;
        rdy_next       = rdy_reg;
        sv_next        = sv_reg;
        sb_next        = sb_reg;
        out_data_next  = out_data_reg;

        // configuration writes
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_CAPTURE_BYTES)
            begin
                cap_next = cfg_data[CAP_W-1:0];
            end
            else if (cfg_index == CFG_MIN_ACTIVE_BYTES)
            begin
                mina_next = cfg_data[MINA_W-1:0];
            end
        end

        // result beat taken
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        // byte 0 shadow follows every store write at address zero
        if (store_req.wr_en && store_req.wr_addr == '0)
        begin
            byte0_next = store_req.wr_data;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_last)
                begin
                    item_next = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    low_next = ~s_axis_tdata[0];
                    rdy_next = s_axis_tdata[1];
                end
            end
            ST_EVAL:
            begin
                sv_next = 1'b0;
                sb_next = 8'd0;
                if (active)
                begin
                    if (!in_window)
                    begin
                        if (drain_ok)
                        begin
                            if (rdy_reg)
                            begin
                                fi_next = fi_reg + WIN_W'(1);
                            end
                        end
                        else
                        begin
                            si_next = '0;
                        end
                    end
                end
                else if (low_reg)
                begin
                    si_next  = SI_W'(1);
                    lab_next = '0;
                    fi_next  = '0;
                end
                else if (byte0_reg != 8'd0)
                begin
                    clr_next  = '0;
                    item_next = 1'b1;
                end
            end
            ST_BIT_WR:
            begin
                lab_next = byte_nr[ADDR_W-1:0];
            end
            ST_FWD_CHK:
            begin
                si_next = si_reg + SI_W'(1);
                if (fwd_ok)
                begin
                    fi_next = fi_reg + WIN_W'(1);
                end
            end
            ST_FWD_DATA:
            begin
                sv_next = 1'b1;
                sb_next = store_rd_data;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {6'd0, active, sb_reg, sv_reg};
                end
            end
            default:
            begin
                sv_next = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cap_reg       <= CAPTURE_BYTES_RESET;
            mina_reg      <= MIN_ACTIVE_BYTES_RESET;
            si_reg        <= '0;
            lab_reg       <= '0;
            fi_reg        <= '0;
            clr_reg       <= '0;
            item_reg      <= 1'b0;
            byte0_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            mina_reg      <= mina_next;
            si_reg        <= si_next;
            lab_reg       <= lab_next;
            fi_reg        <= fi_next;
            clr_reg       <= clr_next;
            item_reg      <= item_next;
            byte0_reg     <= byte0_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        low_reg      <= low_next;
        rdy_reg      <= rdy_next;
        sv_reg       <= sv_next;
        sb_reg       <= sb_next;
        out_data_reg <= out_data_next;
    end

    // a forwarded byte only ever leaves during a capture or drain
    a_send_while_capturing: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[9])
        else $error("send_valid without capturing");

    // an accepted tick is evaluated on the next clock
    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> state_reg == ST_EVAL)
        else $error("accepted tick not evaluated");

    // byte 0 shadow tracks the store
    a_byte0_shadow: assert property (@(posedge clk) disable iff (!rst_n)
        store_req.wr_en && store_req.wr_addr == '0 |=>
        byte0_reg == $past(store_req.wr_data))
        else $error("byte 0 shadow out of step");

endmodule

// ===== hdl/irsc_store.sv =====
// Capture byte store: single write port, single registered read port.
module irsc_store (
    input  logic                clk,
    input  irsc_pkg::store_req_t req,
    output logic [7:0]          rd_data
);
    import irsc_pkg::*;

    logic [7:0] mem [STORE_BYTES];
    logic [7:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
